// ===== hw/rtl/dvdif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dvdif_pkg;

    // section header gate, applied before any other window test
    localparam logic [31:0] HDR_GATE_MASK  = 32'h0007_f840;
    localparam logic [31:0] HDR_GATE_VALUE = 32'h0007_0000;

    // secondary and primary header patterns
    localparam logic [31:0] SEC_MASK   = 32'hff07_ff7f;
    localparam logic [31:0] PRIM_MASK  = 32'hffff_ff7f;
    localparam logic [31:0] HDR_VALUE  = 32'h1f07_003f;

    // marker words and the subcode word that follows a marker
    localparam logic [31:0] MARKER_A   = 32'h003f_0700;
    localparam logic [31:0] MARKER_B   = 32'hff3f_0700;
    localparam logic [31:0] SUBCODE    = 32'hff3f_0701;

    // distance in bytes from a marker to its subcode word
    localparam int unsigned SUBCODE_GAP = 80;

    // scoring constants
    localparam int unsigned MIN_LENGTH      = 5;
    localparam int unsigned PRIM_SHIFT      = 20;     // 1024 * 1024 bytes per primary match
    localparam int unsigned PRIM_STRONG     = 4;
    localparam int unsigned SEC_MIN         = 10;
    localparam int unsigned SEC_FACTOR      = 24000;
    localparam int unsigned SEC_FACTOR_BITS = 15;
    localparam int unsigned COUNT_BITS      = 24;

    // confidence classes
    typedef enum logic [1:0] {
        SCORE_NONE = 2'd0,
        SCORE_LOW  = 2'd1,
        SCORE_HIGH = 2'd2
    } score_t;

    // outcome of testing one window
    typedef struct packed {
        logic secondary;   // secondary header match
        logic primary;     // primary header match (implies secondary)
        logic marker;      // marker word seen
        logic subcode;     // subcode word seen
    } win_hit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dv_dif_stream_probe_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// DV DIF probe scanner: streams a probe buffer one byte per beat and tells
// whether it looks like DV DIF.
// input channel: byte_value and last_byte, handshake byte_valid / byte_stall.
// result channel: score_class, primary_count, secondary_count, handshake
// result_valid / result_stall. exactly one result beat per buffer, sent for
// the byte flagged last_byte; other bytes give no result.
// a byte is registered on accept; bytes other than the last are tested against
// the header patterns in the next cycle, and the result register loads as the
// last byte leaves. one byte is taken every cycle while the result side is free.
// the input register only waits when it holds a last byte and the result
// register still holds an untaken beat; byte_stall is then raised.
// after the last byte all scan state clears, so the next byte starts a new
// buffer. reset (rst_n low) clears the scan state and drops both the input
// and the result beat. counters and the byte position saturate at
// 2^POSITION_BITS - 1; the count outputs carry their low 24 bits.
module dv_dif_stream_probe_scanner #(
    parameter int unsigned POSITION_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       score_class,
    output logic [23:0]      primary_count,
    output logic [23:0]      secondary_count
);

    localparam int unsigned PB   = POSITION_BITS;
    localparam int unsigned PRB  = PB + dvdif_pkg::SEC_FACTOR_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    // input register
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;

    // scan state
    logic [31:0]   window_reg,    window_next;
    logic [PB-1:0] position_reg,  position_next;
    logic [PB-1:0] marker_reg,    marker_next;
    logic [PB-1:0] primary_reg,   primary_next;
    logic [PB-1:0] secondary_reg, secondary_next;
    logic          start_hit_reg, start_hit_next;

    // result register
    logic                  res_valid_reg;
    dvdif_pkg::score_t     res_class_reg, res_class_next;
    logic [23:0]           res_prim_reg;
    logic [23:0]           res_sec_reg;

    logic          out_free;
    logic          proc;
    logic          byte_take;
    logic [31:0]   win_shift;
    logic [PB-1:0] pos_inc;
    logic [PB-1:0] win_pos;
    logic [PB-1:0] marker_dist;
    logic          win_full;
    dvdif_pkg::win_hit_t hit;
    logic [PRB-1:0] sec_scaled;
    logic          len_ok;
    logic          high_conf;

    // flow control
    assign out_free   = !res_valid_reg || !result_stall;
    assign proc       = in_valid_reg && (!in_last_reg || out_free);
    assign byte_stall = in_valid_reg && !proc;
    assign byte_take  = byte_valid && !byte_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_byte_reg <= byte_value;
            in_last_reg <= last_byte;
        end
    end

    // window shift and position
    assign win_shift   = {window_reg[23:0], in_byte_reg};
    assign pos_inc     = (position_reg == POS_MAX) ? position_reg : position_reg + 1'b1;
    assign win_full    = pos_inc >= PB'(4);
    assign win_pos     = pos_inc - PB'(4);
    assign marker_dist = win_pos - marker_reg;

    dvdif_window_check u_check (
        .window (win_shift),
        .hit    (hit)
    );

    // scan state update
    always_comb
    begin
        window_next    = window_reg;
        position_next  = position_reg;
        marker_next    = marker_reg;
        primary_next   = primary_reg;
        secondary_next = secondary_reg;
        start_hit_next = start_hit_reg;
        if (proc)
        begin
            if (in_last_reg)
            begin
                window_next    = '0;
                position_next  = '0;
                marker_next    = '0;
                primary_next   = '0;
                secondary_next = '0;
                start_hit_next = 1'b0;
            end
            else
            begin
                window_next   = win_shift;
                position_next = pos_inc;
                if (win_full)
                begin
                    if (hit.secondary && (secondary_reg != POS_MAX))
                    begin
                        secondary_next = secondary_reg + 1'b1;
                    end
                    if (hit.primary && (win_pos == '0))
                    begin
                        start_hit_next = 1'b1;
                    end
                    if (hit.marker)
                    begin
                        marker_next = win_pos;
                    end
                    // primary header and the subcode word cannot both hit
                    if ((hit.primary
                            || (hit.subcode && (marker_dist == PB'(dvdif_pkg::SUBCODE_GAP))))
                        && (primary_reg != POS_MAX))
                    begin
                        primary_next = primary_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            position_reg  <= '0;
            marker_reg    <= '0;
            primary_reg   <= '0;
            secondary_reg <= '0;
            start_hit_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            position_reg  <= position_next;
            marker_reg    <= marker_next;
            primary_reg   <= primary_next;
            secondary_reg <= secondary_next;
            start_hit_reg <= start_hit_next;
        end
    end

    // confidence score on the last byte, length n = pos_inc
    assign sec_scaled = PRB'(secondary_reg)
                      * PRB'(dvdif_pkg::SEC_FACTOR);
    assign len_ok     = (pos_inc >= PB'(dvdif_pkg::MIN_LENGTH))
                     && (primary_reg != '0)
                     && ((pos_inc >> dvdif_pkg::PRIM_SHIFT) < primary_reg);
    assign high_conf  = (primary_reg > PB'(dvdif_pkg::PRIM_STRONG))
                     || start_hit_reg
                     || ((secondary_reg >= PB'(dvdif_pkg::SEC_MIN))
                         && (PRB'(pos_inc) < sec_scaled));

    always_comb
    begin
        if (!len_ok)
        begin
            res_class_next = dvdif_pkg::SCORE_NONE;
        end
        else if (high_conf)
        begin
            res_class_next = dvdif_pkg::SCORE_HIGH;
        end
        else
        begin
            res_class_next = dvdif_pkg::SCORE_LOW;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            res_class_reg <= res_class_next;
            res_prim_reg  <= dvdif_pkg::COUNT_BITS'(primary_reg);
            res_sec_reg   <= dvdif_pkg::COUNT_BITS'(secondary_reg);
        end
    end

    assign result_valid    = res_valid_reg;
    assign score_class     = res_class_reg;
    assign primary_count   = res_prim_reg;
    assign secondary_count = res_sec_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dvdif_window_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dvdif_window_check (
    input  wire logic [31:0]         window,
    output dvdif_pkg::win_hit_t      hit
);

    logic gate;

    // the header gate must pass before any pattern counts
    assign gate = (window & dvdif_pkg::HDR_GATE_MASK) == dvdif_pkg::HDR_GATE_VALUE;

    // pattern compares
    always_comb
    begin
        hit.secondary = gate
            && ((window & dvdif_pkg::SEC_MASK) == dvdif_pkg::HDR_VALUE);
        hit.primary   = hit.secondary
            && ((window & dvdif_pkg::PRIM_MASK) == dvdif_pkg::HDR_VALUE);
        hit.marker    = gate
            && ((window == dvdif_pkg::MARKER_A) || (window == dvdif_pkg::MARKER_B));
        hit.subcode   = gate && (window == dvdif_pkg::SUBCODE);
    end

endmodule

`default_nettype wire
